// ===== rtl/ttrd_pkg.sv =====
`default_nettype none

package ttrd_pkg;

  localparam int MAX_PERIOD_DEF    = 32;
  localparam int MAX_REPEATS_DEF   = 8;
  localparam int SPACE_RUN_DEF     = 40;
  localparam int HISTORY_DEPTH_DEF = 256;

  localparam int BYTE_W        = 8;
  localparam int MAX_PERIOD_W  = 6;
  localparam int MIN_REPEATS_W = 4;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 6;

  localparam logic [MAX_PERIOD_W-1:0]  MAX_PERIOD_RESET  = 6'd30;
  localparam logic [MIN_REPEATS_W-1:0] MIN_REPEATS_RESET = 4'd5;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PERIOD  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_REPEATS = 1'b1;

  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;

  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic issue_last;
    logic out_full;
  } ctrl_status_t;

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ttrd_ctrl.sv =====
`default_nettype none

module ttrd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire ttrd_pkg::ctrl_status_t status,
  output ttrd_pkg::ctrl_cmd_t        cmd
);
  import ttrd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (status.issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!status.out_full) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ttrd_datapath.sv =====
`default_nettype none

module ttrd_datapath #(
  parameter int MAX_PERIOD    = ttrd_pkg::MAX_PERIOD_DEF,
  parameter int MAX_REPEATS   = ttrd_pkg::MAX_REPEATS_DEF,
  parameter int SPACE_RUN     = ttrd_pkg::SPACE_RUN_DEF,
  parameter int HISTORY_DEPTH = ttrd_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [ttrd_pkg::BYTE_W-1:0]       text_byte,
  input  wire logic                              restart,
  input  wire logic                              cfg_valid,
  input  wire logic [ttrd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ttrd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   repeated,
  input  wire ttrd_pkg::ctrl_cmd_t               cmd,
  output ttrd_pkg::ctrl_status_t                 status
);
  import ttrd_pkg::*;

  localparam int ADDR_W  = $clog2(HISTORY_DEPTH);
  localparam int LEN_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int P_W     = $clog2(MAX_PERIOD + 1);
  localparam int IDX_W   = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int R_W     = $clog2(MAX_REPEATS + 1);
  localparam int NEED_MAX = MAX_REPEATS * MAX_PERIOD;
  localparam int NEED_W  = $clog2(NEED_MAX + 1);
  localparam int BR_MAX  = (SPACE_RUN > MAX_PERIOD) ? SPACE_RUN : MAX_PERIOD;
  localparam int BR_W    = $clog2(BR_MAX + 1);
  localparam int CMP_MAX_A = (HISTORY_DEPTH > NEED_MAX) ? HISTORY_DEPTH : NEED_MAX;
  localparam int CMP_MAX = (CMP_MAX_A > BR_MAX) ? CMP_MAX_A : BR_MAX;
  localparam int CMP_W   = $clog2(CMP_MAX + 1);
  localparam int D_W     = ((ADDR_W > P_W) ? ADDR_W : P_W) + 1;

  logic [MAX_PERIOD_W-1:0]  max_period;
  logic [MIN_REPEATS_W-1:0] min_repeats;

  logic [BYTE_W-1:0] mem [HISTORY_DEPTH];
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] cur_byte;

  logic [ADDR_W-1:0] wpos;
  logic [ADDR_W-1:0] newest;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  len_before;
  logic [BR_W-1:0]   blank_run;

  logic [P_W-1:0]    p_rd;
  logic [P_W-1:0]    p_cmp;
  logic              cmp_valid;
  logic [NEED_W-1:0] need_len;
  logic [NEED_W-1:0] need_run;
  logic              found;
  logic [NEED_W-1:0] run [MAX_PERIOD];

  logic [P_W-1:0]    periods_eff;
  logic [R_W-1:0]    reps_eff;
  logic [ADDR_W-1:0] wr_idx;
  logic [LEN_W-1:0]  len_base;
  logic [LEN_W-1:0]  len_next;
  logic [BR_W-1:0]   blank_base;
  logic [BR_W-1:0]   blank_next;
  logic [D_W-1:0]    newest_ext;
  logic [D_W-1:0]    p_ext;
  logic [D_W-1:0]    rd_diff;
  logic [ADDR_W-1:0] rd_addr;
  logic [IDX_W-1:0]  run_idx;
  logic [NEED_W-1:0] run_old;
  logic [NEED_W-1:0] run_new;
  logic              match;
  logic              hit;

  always_comb begin
    if ({1'b0, max_period} > (MAX_PERIOD_W + 1)'(MAX_PERIOD)) begin
      periods_eff = P_W'(MAX_PERIOD);
    end else begin
      periods_eff = P_W'(max_period);
    end
    if (min_repeats == '0) begin
      reps_eff = R_W'(1);
    end else if ({1'b0, min_repeats} > (MIN_REPEATS_W + 1)'(MAX_REPEATS)) begin
      reps_eff = R_W'(MAX_REPEATS);
    end else begin
      reps_eff = R_W'(min_repeats);
    end
  end

  always_comb begin
    wr_idx     = restart ? '0 : wpos;
    len_base   = restart ? '0 : len;
    len_next   = (len_base == LEN_W'(HISTORY_DEPTH)) ? len_base : len_base + 1'b1;
    blank_base = restart ? '0 : blank_run;
    if (!is_blank(text_byte)) begin
      blank_next = '0;
    end else if (blank_base == BR_W'(BR_MAX)) begin
      blank_next = blank_base;
    end else begin
      blank_next = blank_base + 1'b1;
    end
  end

  always_comb begin
    newest_ext = D_W'(newest);
    p_ext      = D_W'(p_rd);
    if (newest_ext >= p_ext) begin
      rd_diff = newest_ext - p_ext;
    end else begin
      rd_diff = newest_ext + D_W'(HISTORY_DEPTH) - p_ext;
    end
    rd_addr = rd_diff[ADDR_W-1:0];
  end

  always_comb begin
    run_idx = IDX_W'(p_cmp - 1'b1);
    run_old = run[run_idx];
    match   = (CMP_W'(len_before) >= CMP_W'(p_cmp)) && (rd_data == cur_byte);
    if (!match) begin
      run_new = '0;
    end else if (run_old == '1) begin
      run_new = run_old;
    end else begin
      run_new = run_old + 1'b1;
    end
    hit = (p_cmp <= periods_eff)
       && (CMP_W'(len) >= CMP_W'(need_len))
       && (CMP_W'(blank_run) < CMP_W'(p_cmp))
       && (run_new >= need_run);
  end

  assign status.issue_last = (p_rd == P_W'(MAX_PERIOD));
  assign status.out_full   = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_period  <= MAX_PERIOD_RESET;
      min_repeats <= MIN_REPEATS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_PERIOD: begin
          max_period <= cfg_data[MAX_PERIOD_W-1:0];
        end
        REG_MIN_REPEATS: begin
          min_repeats <= cfg_data[MIN_REPEATS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mem[wr_idx] <= text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos      <= '0;
      len       <= '0;
      blank_run <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.issue;
      if (cmd.start) begin
        wpos      <= (wr_idx == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
        len       <= len_next;
        blank_run <= blank_next;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      newest     <= wr_idx;
      len_before <= len_base;
      cur_byte   <= text_byte;
      p_rd       <= P_W'(1);
      need_len   <= NEED_W'(reps_eff);
      need_run   <= NEED_W'(reps_eff) - 1'b1;
      found      <= (CMP_W'(blank_next) >= CMP_W'(SPACE_RUN))
                 && (CMP_W'(len_next) >= CMP_W'(SPACE_RUN));
    end else begin
      if (cmd.issue) begin
        p_cmp <= p_rd;
        p_rd  <= p_rd + 1'b1;
      end
      if (cmp_valid) begin
        run[run_idx] <= run_new;
        found        <= found | hit;
        need_len     <= need_len + NEED_W'(reps_eff);
        need_run     <= need_run + NEED_W'(reps_eff) - 1'b1;
      end
    end
    if (cmd.finish) begin
      repeated <= found;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/text_tail_repetition_detector.sv =====
`default_nettype none

// Takes text one byte per item and returns one item per byte, telling whether the text now
// ends in a run of at least SPACE_RUN blanks or in a non-blank period of up to max_period
// bytes repeated min_repeats times. An item is accepted only while the block is idle; the
// block then scans every candidate period length, drains and emits the result, and only
// then takes the next item. The pace is set by the single read port of the history memory,
// which is read once for every candidate period length. A result held by a stalled output
// keeps the result of the next item, and with it any further item, waiting until it has
// been taken. Per period length the block keeps a running count of trailing bytes that
// equal the byte one period back, so no history beyond one period is ever scanned. No
// clearing pass follows reset.
module text_tail_repetition_detector #(
  parameter int MAX_PERIOD    = ttrd_pkg::MAX_PERIOD_DEF,
  parameter int MAX_REPEATS   = ttrd_pkg::MAX_REPEATS_DEF,
  parameter int SPACE_RUN     = ttrd_pkg::SPACE_RUN_DEF,
  parameter int HISTORY_DEPTH = ttrd_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [ttrd_pkg::BYTE_W-1:0]      text_byte,
  input  wire logic                             restart,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  repeated,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ttrd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ttrd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ttrd_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  ttrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ttrd_datapath #(
    .MAX_PERIOD    (MAX_PERIOD),
    .MAX_REPEATS   (MAX_REPEATS),
    .SPACE_RUN     (SPACE_RUN),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .text_byte (text_byte),
    .restart   (restart),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .repeated  (repeated),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire
